[hdl/ohmd_pkg.sv]
`default_nettype none

package ohmd_pkg;

  localparam int HEADER_BYTES          = 80;
  localparam int SLOT_FIRST            = 4;
  localparam int SLOT_END              = 60;
  localparam int NUM_SLOTS             = 14;
  localparam int TYPE_BYTES            = 4;
  localparam int OFS_W                 = 14;
  localparam int TAG_W                 = 4;
  localparam int HPOS_W                = 6;
  localparam int DEF_MAX_PAYLOAD_BYTES = 4096;

  localparam logic [TAG_W-1:0] TAG_TYPE = 4'd0;
  localparam logic [TAG_W-1:0] TAG_NONE = 4'd15;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_NINE  = 8'd57;
  localparam logic [7:0] ASCII_DASH  = 8'd45;
  localparam logic [7:0] ASCII_ONE   = 8'd49;

  // per-step control from the byte counter to the parser and tag tracker
  typedef struct packed {
    logic              hdr;   // byte is a header slot character
    logic              pay;   // byte is an emitted payload byte
    logic              clr;   // last byte of the message
    logic [HPOS_W-1:0] hpos;  // header byte position
  } ohmd_ctl_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             start;
  } ohmd_tag_t;

  // expected character of the absent marker "00-1" in each column
  function automatic logic [7:0] absent_char(input logic [1:0] col);
    logic [7:0] c;
    unique case (col)
      2'd0:    c = ASCII_ZERO;
      2'd1:    c = ASCII_ZERO;
      2'd2:    c = ASCII_DASH;
      default: c = ASCII_ONE;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[hdl/offset_header_message_deframer_unit.sv]
`default_nettype none

// Chan  Handshake            Payload fields, in order
// ----  -------------------  ---------------------------------------------------------------
// in    in_valid/in_stall    msg_byte end_of_msg
// out   out_valid/out_stall  field_tag payload_byte payload_pos field_start msg_last header_error
//
// One byte per cycle sustained while out_stall is low. A payload byte passes through the input
// register and then the result register, where out_valid rises for it; out_stall can hold it
// in either register.
// Header bytes and overlong payload bytes produce no output transaction.
// rst is synchronous; state is also cleared by the byte that carries end_of_msg.
// out_stall holds the result register and, through it, the input register;
// in_stall is raised only while both registers are full and the output stalls.

module offset_header_message_deframer_unit #(
  parameter int MAX_PAYLOAD_BYTES = ohmd_pkg::DEF_MAX_PAYLOAD_BYTES,
  localparam int POS_W  = $clog2(MAX_PAYLOAD_BYTES),
  localparam int BPOS_W = $clog2(ohmd_pkg::HEADER_BYTES + MAX_PAYLOAD_BYTES + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [7:0]                 msg_byte,
  input  wire logic                       end_of_msg,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [ohmd_pkg::TAG_W-1:0]      field_tag,
  output logic [7:0]                      payload_byte,
  output logic [POS_W-1:0]                payload_pos,
  output logic                            field_start,
  output logic                            msg_last,
  output logic                            header_error
);

  localparam logic [BPOS_W-1:0] POS_LIMIT =
    BPOS_W'(ohmd_pkg::HEADER_BYTES + MAX_PAYLOAD_BYTES);

  // input register
  logic       in_vld_r;
  logic [7:0] byte_r;
  logic       last_r;

  // message byte counter, saturates past the longest payload
  logic [BPOS_W-1:0] bpos;
  logic [BPOS_W-1:0] rel_full;

  logic adv;   // result register free this cycle
  logic step;  // the registered byte is processed now
  logic in_hdr;
  logic in_pay;

  ohmd_pkg::ohmd_ctl_t ctl;
  ohmd_pkg::ohmd_tag_t tag_info;
  logic [POS_W-1:0]    rel;

  logic [ohmd_pkg::NUM_SLOTS-1:0][ohmd_pkg::OFS_W-1:0] offsets;
  logic [ohmd_pkg::NUM_SLOTS-1:0]                      present;
  logic                                                error_seen;

  assign adv      = !out_valid || !out_stall;
  assign step     = in_vld_r && adv;
  assign in_stall = in_vld_r && !adv;

  assign in_hdr   = (bpos >= BPOS_W'(ohmd_pkg::SLOT_FIRST)) &&
                    (bpos <  BPOS_W'(ohmd_pkg::SLOT_END));
  assign in_pay   = (bpos >= BPOS_W'(ohmd_pkg::HEADER_BYTES)) && (bpos != POS_LIMIT);
  assign rel_full = bpos - BPOS_W'(ohmd_pkg::HEADER_BYTES);
  assign rel      = rel_full[POS_W-1:0];

  assign ctl.hdr  = step && in_hdr;
  assign ctl.pay  = step && in_pay;
  assign ctl.clr  = step && last_r;
  assign ctl.hpos = bpos[ohmd_pkg::HPOS_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      byte_r <= msg_byte;
      last_r <= end_of_msg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bpos <= '0;
    end else if (step) begin
      if (last_r) begin
        bpos <= '0;
      end else if (bpos != POS_LIMIT) begin
        bpos <= bpos + 1'b1;
      end
    end
  end

  ohmd_slot_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .ch         (byte_r),
    .offsets    (offsets),
    .present    (present),
    .error_seen (error_seen)
  );

  ohmd_tag_track #(
    .POS_W (POS_W)
  ) u_tag (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .rel      (rel),
    .offsets  (offsets),
    .present  (present),
    .tag_info (tag_info)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= ctl.pay;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pay) begin
      field_tag    <= tag_info.tag;
      payload_byte <= byte_r;
      payload_pos  <= rel;
      field_start  <= tag_info.start;
      msg_last     <= last_r;
      header_error <= error_seen;  // header is complete before any payload byte
    end
  end

  // ---- assertions ----

  // type bytes always carry the type tag
  a_type_tag: assert property (@(posedge clk) disable iff (rst)
    out_valid && (payload_pos < POS_W'(ohmd_pkg::TYPE_BYTES)) |->
      field_tag == ohmd_pkg::TAG_TYPE)
    else $error("type byte carries a non-type tag");

  // first payload byte of a message always opens a field
  a_first_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && (payload_pos == '0) |-> field_start)
    else $error("first payload byte lacks field_start");

  // the last byte of a message rewinds the byte counter
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    step && last_r |=> bpos == '0)
    else $error("byte counter not cleared after end of message");

  // the input side stalls only behind a stalled full result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall && in_vld_r)
    else $error("input stalled without output back-pressure");

endmodule

`default_nettype wire

[hdl/ohmd_slot_parser.sv]
`default_nettype none

module ohmd_slot_parser (
  input  wire logic                                               clk,
  input  wire logic                                               rst,
  input  wire ohmd_pkg::ohmd_ctl_t                                ctl,
  input  wire logic [7:0]                                         ch,
  output logic [ohmd_pkg::NUM_SLOTS-1:0][ohmd_pkg::OFS_W-1:0]     offsets,
  output logic [ohmd_pkg::NUM_SLOTS-1:0]                          present,
  output logic                                                    error_seen
);

  logic [ohmd_pkg::OFS_W-1:0] acc;
  logic                       absent;
  logic                       bad;

  logic [1:0]                 col;
  logic [3:0]                 slot;
  logic                       is_digit;
  logic [ohmd_pkg::OFS_W+3:0] acc_x10;
  logic [ohmd_pkg::OFS_W-1:0] acc_next;
  logic                       absent_next;
  logic                       bad_next;
  logic [ohmd_pkg::HPOS_W-1:0] slot_pos;

  assign col      = ctl.hpos[1:0];
  assign slot_pos = ctl.hpos - ohmd_pkg::HPOS_W'(ohmd_pkg::SLOT_FIRST);
  assign slot     = slot_pos[5:2];
  assign is_digit = (ch >= ohmd_pkg::ASCII_ZERO) && (ch <= ohmd_pkg::ASCII_NINE);

  // acc*10 + digit, kept to 14 bits
  assign acc_x10 = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0}
                 + {10'd0, ch - ohmd_pkg::ASCII_ZERO};
  assign acc_next    = is_digit ? acc_x10[ohmd_pkg::OFS_W-1:0] : acc;
  assign absent_next = absent && (ch == ohmd_pkg::absent_char(col));
  assign bad_next    = bad || !is_digit;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      absent     <= 1'b1;
      bad        <= 1'b0;
      present    <= '0;
      error_seen <= 1'b0;
    end else if (ctl.clr) begin
      acc        <= '0;
      absent     <= 1'b1;
      bad        <= 1'b0;
      present    <= '0;
      error_seen <= 1'b0;
    end else if (ctl.hdr) begin
      if (col == 2'd3) begin
        if (absent_next) begin
          present[slot] <= 1'b0;
        end else if (bad_next) begin
          present[slot] <= 1'b0;
          error_seen    <= 1'b1;
        end else begin
          present[slot] <= 1'b1;
          offsets[slot] <= acc_next;
        end
        acc    <= '0;
        absent <= 1'b1;
        bad    <= 1'b0;
      end else begin
        acc    <= acc_next;
        absent <= absent_next;
        bad    <= bad_next;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/ohmd_tag_track.sv]
`default_nettype none

module ohmd_tag_track #(
  parameter int POS_W = 12
) (
  input  wire logic                                               clk,
  input  wire logic                                               rst,
  input  wire ohmd_pkg::ohmd_ctl_t                                ctl,
  input  wire logic [POS_W-1:0]                                   rel,
  input  wire logic [ohmd_pkg::NUM_SLOTS-1:0][ohmd_pkg::OFS_W-1:0] offsets,
  input  wire logic [ohmd_pkg::NUM_SLOTS-1:0]                     present,
  output ohmd_pkg::ohmd_tag_t                                     tag_info
);

  // Positions rise by one per payload byte, so the covering field only
  // changes where the position hits an offset exactly.
  logic [ohmd_pkg::TAG_W-1:0] best;
  logic [ohmd_pkg::TAG_W-1:0] best_next;
  logic [ohmd_pkg::TAG_W-1:0] prev;
  logic [ohmd_pkg::OFS_W-1:0] rel_x;

  assign rel_x = {{(ohmd_pkg::OFS_W-POS_W){1'b0}}, rel};

  always_comb begin
    best_next = best;
    for (int k = 0; k < ohmd_pkg::NUM_SLOTS; k++) begin
      if (present[k] && (offsets[k] == rel_x)) begin
        best_next = ohmd_pkg::TAG_W'(k + 1);  // higher slot wins a tie
      end
    end
  end

  assign tag_info.tag   = (rel < POS_W'(ohmd_pkg::TYPE_BYTES)) ? ohmd_pkg::TAG_TYPE
                                                               : best_next;
  assign tag_info.start = (tag_info.tag != prev);

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      best <= ohmd_pkg::TAG_TYPE;
      prev <= ohmd_pkg::TAG_NONE;
    end else if (ctl.pay) begin
      best <= best_next;
      prev <= tag_info.tag;
    end
  end

endmodule

`default_nettype wire
